// ----- rtl/pairwise_gravity_force_macros.svh -----
// ---------------------------------------------------------------------------
// pairwise gravity force assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef PAIRWISE_GRAVITY_FORCE_MACROS_SVH
`define PAIRWISE_GRAVITY_FORCE_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define PGF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pgf assertion failed");
// condition must never be seen outside reset
`define PGF_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("pgf forbidden condition seen");
`else
`define PGF_ASSERT(label, clk, rst, prop)
`define PGF_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ----- rtl/pgf_pkg.sv -----
// ---------------------------------------------------------------------------
// pgf_pkg
// shared constants and types of the pairwise gravity force pipeline
// ---------------------------------------------------------------------------
`default_nettype none

package pgf_pkg;

   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST = 8'd1;

   localparam logic [31:0] G_RESET    = 32'd73381406;
   localparam logic [23:0] DMIN_RESET = 24'd327680;

   localparam logic [43:0] F_LIMIT    = 44'h800_0000_0000;
   localparam logic [16:0] SLOPE_ONE  = 17'h1_0000;
   localparam logic [33:0] SQRT_BIAS  = 34'h1_0000_0000;
   localparam logic [26:0] CAP_POS    = 27'd6553600;
   localparam logic [26:0] CAP_NEG    = 27'd67108864;
   localparam logic [26:0] QUOT_SAT   = 27'h7FF_FFFF;

   localparam int FDIV_STAGES = 44;
   localparam int SDIV_STAGES = 16;
   localparam int SQRT_STAGES = 32;
   localparam int RDIV_STAGES = 27;
   localparam int SLOPE_LAT   = SDIV_STAGES + SQRT_STAGES + 2;
   localparam int FDIV_PAD    = SLOPE_LAT - FDIV_STAGES - 2;

   typedef struct packed {
      logic [23:0] first_x;
      logic [23:0] first_y;
      logic [23:0] first_mass;
      logic [23:0] second_x;
      logic [23:0] second_y;
      logic [23:0] second_mass;
      logic        gate_by_distance;
   } req_type;

   typedef struct packed {
      logic signed [26:0] force_x;
      logic signed [26:0] force_y;
      logic               applied;
      logic               coincident;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic gated;
      logic coinc;
      logic neg;
   } tag_type;

   typedef struct packed {
      logic [23:0] adx;
      logic [23:0] ady;
      logic [48:0] d2;
      logic [39:0] gm;
   } geom_type;

endpackage

`default_nettype wire

// ----- rtl/pgf_if.sv -----
// ---------------------------------------------------------------------------
// pgf channel interfaces
// request, response and register write channels with valid/ready
// ---------------------------------------------------------------------------
`default_nettype none

interface pgf_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] first_x;
   logic [23:0] first_y;
   logic [23:0] first_mass;
   logic [23:0] second_x;
   logic [23:0] second_y;
   logic [23:0] second_mass;
   logic        gate_by_distance;
   modport source (output valid, first_x, first_y, first_mass, second_x, second_y,
                   second_mass, gate_by_distance, input ready);
   modport sink (input valid, first_x, first_y, first_mass, second_x, second_y,
                 second_mass, gate_by_distance, output ready);
endinterface

interface pgf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [26:0] force_x;
   logic signed [26:0] force_y;
   logic               applied;
   logic               coincident;
   modport source (output valid, force_x, force_y, applied, coincident, input ready);
   modport sink (input valid, force_x, force_y, applied, coincident, output ready);
endinterface

interface pgf_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/pgf_front.sv -----
// ---------------------------------------------------------------------------
// pgf_front
// deltas, squared distance, mass product, scaled G*m1*m2 and gating flags
// ---------------------------------------------------------------------------
`default_nettype none

module pgf_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  pgf_pkg::req_type   req,
   input  logic [31:0]        gravity,
   input  logic [23:0]        min_dist,
   output pgf_pkg::tag_type   tag_out,
   output pgf_pkg::geom_type  geom_out
);

   typedef struct packed {
      logic [23:0] adx;
      logic [23:0] ady;
      logic        neg;
      logic [23:0] m1;
      logic [23:0] m2;
      logic        gate;
   } st1_type;

   typedef struct packed {
      logic [23:0] adx;
      logic [23:0] ady;
      logic        neg;
      logic [47:0] sqx;
      logic [47:0] sqy;
      logic [47:0] mm;
      logic        gate;
   } st2_type;

   typedef struct packed {
      logic [23:0] adx;
      logic [23:0] ady;
      logic        neg;
      logic [48:0] d2;
      logic [47:0] mdsq;
      logic [55:0] ghi;
      logic [55:0] glo;
      logic        gate;
   } st3_type;

   logic [24:0] dx;
   logic [24:0] dy;
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   st1_type     s1_in, s1_ff;
   st2_type     s2_in, s2_ff;
   st3_type     s3_in, s3_ff;
   logic [56:0] gsum;
   pgf_pkg::tag_type  tag_in, tag_ff;
   pgf_pkg::geom_type geom_in, geom_ff;

   always_comb begin
      dx = {1'b0, req.first_x} - {1'b0, req.second_x};
      dy = {1'b0, req.first_y} - {1'b0, req.second_y};
      s1_in.adx  = dx[24] ? 24'(25'd0 - dx) : dx[23:0];
      s1_in.ady  = dy[24] ? 24'(25'd0 - dy) : dy[23:0];
      // vertical pair takes the sign of dy alone
      s1_in.neg  = (dx == 25'd0) ? dy[24] : (dx[24] ^ dy[24]);
      s1_in.m1   = req.first_mass;
      s1_in.m2   = req.second_mass;
      s1_in.gate = req.gate_by_distance;
   end

   always_comb begin
      s2_in.adx  = s1_ff.adx;
      s2_in.ady  = s1_ff.ady;
      s2_in.neg  = s1_ff.neg;
      s2_in.sqx  = 48'(s1_ff.adx) * 48'(s1_ff.adx);
      s2_in.sqy  = 48'(s1_ff.ady) * 48'(s1_ff.ady);
      s2_in.mm   = 48'(s1_ff.m1) * 48'(s1_ff.m2);
      s2_in.gate = s1_ff.gate;
   end

   always_comb begin
      s3_in.adx  = s2_ff.adx;
      s3_in.ady  = s2_ff.ady;
      s3_in.neg  = s2_ff.neg;
      s3_in.d2   = {1'b0, s2_ff.sqx} + {1'b0, s2_ff.sqy};
      s3_in.mdsq = 48'(min_dist) * 48'(min_dist);
      // G*mm split in two 32x24 halves
      s3_in.ghi  = 56'(gravity) * 56'(s2_ff.mm[47:24]);
      s3_in.glo  = 56'(gravity) * 56'(s2_ff.mm[23:0]);
      s3_in.gate = s2_ff.gate;
   end

   always_comb begin
      gsum          = {1'b0, s3_ff.ghi} + {25'd0, s3_ff.glo[55:24]};
      geom_in.adx   = s3_ff.adx;
      geom_in.ady   = s3_ff.ady;
      geom_in.d2    = s3_ff.d2;
      geom_in.gm    = gsum[55:16];
      tag_in.valid  = v3_ff;
      tag_in.coinc  = (s3_ff.d2 == 49'd0);
      tag_in.gated  = s3_ff.gate && (s3_ff.d2 <= {1'b0, s3_ff.mdsq});
      tag_in.neg    = s3_ff.neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff   <= s1_in;
         s2_ff   <= s2_in;
         s3_ff   <= s3_in;
         geom_ff <= geom_in;
         tag_ff  <= tag_in;
      end
   end

   always_comb begin
      tag_out       = tag_ff;
      tag_out.valid = v4_ff;
   end

   assign geom_out = geom_ff;

endmodule

`default_nettype wire

// ----- rtl/pgf_fdiv.sv -----
// ---------------------------------------------------------------------------
// pgf_fdiv
// pipelined restoring divider for the force magnitude gm*2^32/d2
// ---------------------------------------------------------------------------
`default_nettype none

module pgf_fdiv (
   input  logic        clock,
   input  logic        en,
   input  logic [39:0] gm,
   input  logic [48:0] d2,
   output logic [43:0] force_mag
);

   localparam int NS = pgf_pkg::FDIV_STAGES;
   localparam int NP = pgf_pkg::FDIV_PAD;

   logic [48:0] rem_ff [NS];
   logic [43:0] low_ff [NS];
   logic [48:0] d2_ff  [NS];
   logic [43:0] q_ff   [NS+1];
   logic        ovf_ff [NS+1];
   logic [43:0] pad_ff [NP+1];
   logic [43:0] sel_in;

   // a quotient of 2^44 or more saturates, checked on the top bits
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {21'd0, gm[39:12]};
         low_ff[0] <= {gm[11:0], 32'd0};
         d2_ff[0]  <= d2;
         q_ff[0]   <= 44'd0;
         ovf_ff[0] <= ({21'd0, gm[39:12]} >= d2);
      end
   end

   for (genvar k = 1; k <= NS; k++) begin : g_step
      logic [49:0] trial;
      logic        take;
      logic [48:0] rem_in;
      always_comb begin
         trial  = {rem_ff[k-1], low_ff[k-1][43]};
         take   = (trial >= {1'b0, d2_ff[k-1]});
         rem_in = take ? 49'(trial - {1'b0, d2_ff[k-1]}) : trial[48:0];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k]   <= {q_ff[k-1][42:0], take};
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
      if (k < NS) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
               low_ff[k] <= {low_ff[k-1][42:0], 1'b0};
               d2_ff[k]  <= d2_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      if (ovf_ff[NS] || (q_ff[NS] > pgf_pkg::F_LIMIT)) begin
         sel_in = pgf_pkg::F_LIMIT;
      end else begin
         sel_in = q_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pad_ff[0] <= sel_in;
      end
   end

   // delay line to line up with the slope and root lane
   for (genvar p = 1; p <= NP; p++) begin : g_pad
      always_ff @(posedge clock) begin
         if (en) begin
            pad_ff[p] <= pad_ff[p-1];
         end
      end
   end

   assign force_mag = pad_ff[NP];

endmodule

`default_nettype wire

// ----- rtl/pgf_slope.sv -----
// ---------------------------------------------------------------------------
// pgf_slope
// clamped slope |dy|/|dx| by pipelined division, then sqrt of (1+s^2)
// ---------------------------------------------------------------------------
`default_nettype none

module pgf_slope (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  pgf_pkg::tag_type  tag_in,
   input  logic [23:0]       adx,
   input  logic [23:0]       ady,
   output pgf_pkg::tag_type  tag_out,
   output logic [16:0]       smag,
   output logic [31:0]       root
);

   localparam int ND = pgf_pkg::SDIV_STAGES;
   localparam int NR = pgf_pkg::SQRT_STAGES;

   logic [23:0]      drem_ff [ND];
   logic [23:0]      dadx_ff [ND];
   logic [15:0]      dq_ff   [ND+1];
   logic             dsel_ff [ND+1];
   pgf_pkg::tag_type dtag_ff [ND+1];

   logic [63:0]      v_ff    [NR];
   logic [33:0]      rrem_ff [NR];
   logic [31:0]      rq_ff   [NR+1];
   logic [16:0]      smag_ff [NR+1];
   pgf_pkg::tag_type rtag_ff [NR+1];

   logic [16:0]      smag_in;
   logic [33:0]      vh_in;
   pgf_pkg::tag_type stag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         dtag_ff[0].valid <= 1'b0;
      end else if (en) begin
         dtag_ff[0] <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         drem_ff[0] <= ady;
         dadx_ff[0] <= adx;
         dq_ff[0]   <= 16'd0;
         // steep or vertical pairs clamp to one
         dsel_ff[0] <= (adx == 24'd0) || (ady >= adx);
      end
   end

   for (genvar k = 1; k <= ND; k++) begin : g_div
      logic [24:0] trial;
      logic        take;
      logic [23:0] rem_in;
      always_comb begin
         trial  = {drem_ff[k-1], 1'b0};
         take   = (trial >= {1'b0, dadx_ff[k-1]});
         rem_in = take ? 24'(trial - {1'b0, dadx_ff[k-1]}) : trial[23:0];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dtag_ff[k].valid <= 1'b0;
         end else if (en) begin
            dtag_ff[k] <= dtag_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dq_ff[k]   <= {dq_ff[k-1][14:0], take};
            dsel_ff[k] <= dsel_ff[k-1];
         end
      end
      if (k < ND) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               drem_ff[k] <= rem_in;
               dadx_ff[k] <= dadx_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      smag_in   = dsel_ff[ND] ? pgf_pkg::SLOPE_ONE : {1'b0, dq_ff[ND]};
      vh_in     = pgf_pkg::SQRT_BIAS + 34'(smag_in) * 34'(smag_in);
      stag_in   = dtag_ff[ND];
      // a zero slope never carries a sign
      stag_in.neg = dtag_ff[ND].neg && (smag_in != 17'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rtag_ff[0].valid <= 1'b0;
      end else if (en) begin
         rtag_ff[0] <= stag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff[0]    <= {vh_in, 30'd0};
         rrem_ff[0] <= 34'd0;
         rq_ff[0]   <= 32'd0;
         smag_ff[0] <= smag_in;
      end
   end

   // digit by digit square root, one result bit per stage
   for (genvar k = 1; k <= NR; k++) begin : g_root
      logic [35:0] part;
      logic [35:0] trial;
      logic        take;
      logic [33:0] rem_in;
      always_comb begin
         part   = {rrem_ff[k-1], v_ff[k-1][63:62]};
         trial  = {2'b00, rq_ff[k-1], 2'b01};
         take   = (part >= trial);
         rem_in = take ? 34'(part - trial) : part[33:0];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            rtag_ff[k].valid <= 1'b0;
         end else if (en) begin
            rtag_ff[k] <= rtag_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rq_ff[k]   <= {rq_ff[k-1][30:0], take};
            smag_ff[k] <= smag_ff[k-1];
         end
      end
      if (k < NR) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rrem_ff[k] <= rem_in;
               v_ff[k]    <= {v_ff[k-1][61:0], 2'b00};
            end
         end
      end
   end

   assign tag_out = rtag_ff[NR];
   assign smag    = smag_ff[NR];
   assign root    = rq_ff[NR];

endmodule

`default_nettype wire

// ----- rtl/pgf_comp.sv -----
// ---------------------------------------------------------------------------
// pgf_comp
// force components: F*2^31/r and F*s*2^15/r in two divider lanes, capped
// ---------------------------------------------------------------------------
`default_nettype none

module pgf_comp (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  pgf_pkg::tag_type  tag_in,
   input  logic [43:0]       force_mag,
   input  logic [16:0]       smag,
   input  logic [31:0]       root,
   output logic              out_valid,
   output pgf_pkg::rsp_type  out_rsp
);

   localparam int NS = pgf_pkg::RDIV_STAGES;

   pgf_pkg::tag_type c0_tag_ff, c1_tag_ff;
   logic [38:0]      pl_ff, ph_ff;
   logic [43:0]      f0_ff, f1_ff;
   logic [31:0]      r0_ff, r1_ff;
   logic [60:0]      prod_ff;

   pgf_pkg::tag_type tag_ff [NS+1];
   logic [31:0]      r_ff   [NS];
   logic [31:0]      rem_ff [2][NS];
   logic [26:0]      low_ff [2][NS];
   logic [26:0]      q_ff   [2][NS+1];
   logic             ovf_ff [2][NS+1];

   logic [31:0]      init_rem [2];
   logic [26:0]      init_low [2];
   logic             init_ovf [2];

   logic [26:0]      qx, qy, fx, fymag, lim;
   logic             out_valid_ff;
   pgf_pkg::rsp_type rsp_in, rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_tag_ff.valid <= 1'b0;
         c1_tag_ff.valid <= 1'b0;
      end else if (en) begin
         c0_tag_ff <= tag_in;
         c1_tag_ff <= c0_tag_ff;
      end
   end

   // F*s in two 22x17 partial products, summed in the register stage after them
   always_ff @(posedge clock) begin
      if (en) begin
         pl_ff   <= 39'(force_mag[21:0]) * 39'(smag);
         ph_ff   <= 39'(force_mag[43:22]) * 39'(smag);
         f0_ff   <= force_mag;
         r0_ff   <= root;
         prod_ff <= {ph_ff, 22'd0} + 61'(pl_ff);
         f1_ff   <= f0_ff;
         r1_ff   <= r0_ff;
      end
   end

   always_comb begin
      init_ovf[0] = ({f1_ff, 4'd0} >= {16'd0, r1_ff});
      init_rem[0] = {f1_ff[27:0], 4'd0};
      init_low[0] = 27'd0;
      init_ovf[1] = (prod_ff[60:12] >= {17'd0, r1_ff});
      init_rem[1] = prod_ff[43:12];
      init_low[1] = {prod_ff[11:0], 15'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[0].valid <= 1'b0;
      end else if (en) begin
         tag_ff[0] <= c1_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0] <= r1_ff;
      end
   end

   for (genvar k = 1; k <= NS; k++) begin : g_tag
      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k].valid <= 1'b0;
         end else if (en) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
      if (k < NS) begin : g_r
         always_ff @(posedge clock) begin
            if (en) begin
               r_ff[k] <= r_ff[k-1];
            end
         end
      end
   end

   // lane 0 gives force_x, lane 1 gives |force_y|
   for (genvar l = 0; l < 2; l++) begin : g_lane
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[l][0] <= init_rem[l];
            low_ff[l][0] <= init_low[l];
            q_ff[l][0]   <= 27'd0;
            ovf_ff[l][0] <= init_ovf[l];
         end
      end
      for (genvar k = 1; k <= NS; k++) begin : g_step
         logic [32:0] trial;
         logic        take;
         logic [31:0] rem_in;
         always_comb begin
            trial  = {rem_ff[l][k-1], low_ff[l][k-1][26]};
            take   = (trial >= {1'b0, r_ff[k-1]});
            rem_in = take ? 32'(trial - {1'b0, r_ff[k-1]}) : trial[31:0];
         end
         always_ff @(posedge clock) begin
            if (en) begin
               q_ff[l][k]   <= {q_ff[l][k-1][25:0], take};
               ovf_ff[l][k] <= ovf_ff[l][k-1];
            end
         end
         if (k < NS) begin : g_carry
            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[l][k] <= rem_in;
                  low_ff[l][k] <= {low_ff[l][k-1][25:0], 1'b0};
               end
            end
         end
      end
   end

   always_comb begin
      qx    = ovf_ff[0][NS] ? pgf_pkg::QUOT_SAT : q_ff[0][NS];
      qy    = ovf_ff[1][NS] ? pgf_pkg::QUOT_SAT : q_ff[1][NS];
      fx    = (qx > pgf_pkg::CAP_POS) ? pgf_pkg::CAP_POS : qx;
      lim   = tag_ff[NS].neg ? pgf_pkg::CAP_NEG : pgf_pkg::CAP_POS;
      fymag = (qy > lim) ? lim : qy;
      rsp_in.coincident = tag_ff[NS].coinc;
      if (tag_ff[NS].coinc || tag_ff[NS].gated) begin
         rsp_in.force_x = 27'sd0;
         rsp_in.force_y = 27'sd0;
         rsp_in.applied = 1'b0;
      end else begin
         rsp_in.force_x = $signed(fx);
         rsp_in.force_y = tag_ff[NS].neg ? $signed(27'(27'd0 - fymag)) : $signed(fymag);
         rsp_in.applied = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= tag_ff[NS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/pairwise_gravity_force.sv -----
// ---------------------------------------------------------------------------
// pairwise_gravity_force
// gravitational force components between two bodies, fully pipelined
// ---------------------------------------------------------------------------
// req_ch carries two positions, two masses and the gating bit; rsp_ch returns
// force_x, force_y, applied and coincident, one transaction per request, in
// order. csr_ch writes gravity_constant (index 0) and min_distance (index 1);
// other indexes are dropped. csr_ch is always ready and must only be written
// while no request is in flight.
// Throughput is one transaction per cycle while the output buffer has room.
// From request to response valid a transaction passes 4 front stages, 50
// stages of slope division and 32-step square root (the 44-bit force
// divider runs alongside, padded to match), 31 stages of component multiply
// and division, and one output buffer stage. The slope lane sets the depth.
// Reset is synchronous: it empties the pipeline and the output buffer and
// loads the register defaults. A 2-entry output buffer keeps req_ch.ready
// high while one result waits; when it holds two, the whole pipeline holds
// and req_ch.ready drops until rsp_ch takes a result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "pairwise_gravity_force_macros.svh"

module pairwise_gravity_force (
   input  logic      clock,
   input  logic      reset,
   pgf_req_if.sink   req_ch,
   pgf_rsp_if.source rsp_ch,
   pgf_csr_if.sink   csr_ch
);

   logic [31:0]       gravity_ff;
   logic [23:0]       min_dist_ff;
   logic              en;
   pgf_pkg::req_type  req;
   pgf_pkg::tag_type  front_tag, slope_tag;
   pgf_pkg::geom_type geom;
   logic [43:0]       force_mag;
   logic [16:0]       smag;
   logic [31:0]       root;
   logic              pipe_valid;
   pgf_pkg::rsp_type  pipe_rsp;

   pgf_pkg::rsp_type  slot_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff  <= pgf_pkg::G_RESET;
         min_dist_ff <= pgf_pkg::DMIN_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            pgf_pkg::CSR_GRAVITY:  gravity_ff  <= csr_ch.data;
            pgf_pkg::CSR_MIN_DIST: min_dist_ff <= csr_ch.data[23:0];
            default: ;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   always_comb begin
      req.first_x          = req_ch.first_x;
      req.first_y          = req_ch.first_y;
      req.first_mass       = req_ch.first_mass;
      req.second_x         = req_ch.second_x;
      req.second_y         = req_ch.second_y;
      req.second_mass      = req_ch.second_mass;
      req.gate_by_distance = req_ch.gate_by_distance;
   end

   // pipeline moves whenever the output buffer has a free slot
   assign en           = (cnt_ff != 2'd2);
   assign req_ch.ready = en;

   pgf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_ch.valid),
      .req      (req),
      .gravity  (gravity_ff),
      .min_dist (min_dist_ff),
      .tag_out  (front_tag),
      .geom_out (geom)
   );

   pgf_fdiv u_fdiv (
      .clock     (clock),
      .en        (en),
      .gm        (geom.gm),
      .d2        (geom.d2),
      .force_mag (force_mag)
   );

   pgf_slope u_slope (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .tag_in  (front_tag),
      .adx     (geom.adx),
      .ady     (geom.ady),
      .tag_out (slope_tag),
      .smag    (smag),
      .root    (root)
   );

   pgf_comp u_comp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .tag_in    (slope_tag),
      .force_mag (force_mag),
      .smag      (smag),
      .root      (root),
      .out_valid (pipe_valid),
      .out_rsp   (pipe_rsp)
   );

   assign push   = pipe_valid && en;
   assign pop    = rsp_ch.valid && rsp_ch.ready;
   assign cnt_in = 2'(cnt_ff + {1'b0, push} - {1'b0, pop});

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= pipe_rsp;
      end
   end

   assign rsp_ch.valid      = (cnt_ff != 2'd0);
   assign rsp_ch.force_x    = slot_ff[rd_ptr_ff].force_x;
   assign rsp_ch.force_y    = slot_ff[rd_ptr_ff].force_y;
   assign rsp_ch.applied    = slot_ff[rd_ptr_ff].applied;
   assign rsp_ch.coincident = slot_ff[rd_ptr_ff].coincident;

   `PGF_ASSERT_NEVER(a_buf_bound, clock, reset, cnt_ff == 2'd3)
   `PGF_ASSERT(a_full_holds, clock, reset, (cnt_ff == 2'd2) && !pop |=> cnt_ff == 2'd2)
   `PGF_ASSERT(a_coinc_zero, clock, reset, rsp_ch.valid && rsp_ch.coincident |-> !rsp_ch.applied && rsp_ch.force_x == 27'sd0 && rsp_ch.force_y == 27'sd0)
   `PGF_ASSERT(a_fx_nonneg, clock, reset, rsp_ch.valid |-> !rsp_ch.force_x[26])

endmodule

`default_nettype wire
